/* hdl/str_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stepper trapezoid ramp generator.
// No dependencies; imported by every module of the block.
package str_pkg;

  localparam logic [1:0] CMD_REL     = 2'd0;
  localparam logic [1:0] CMD_ABS     = 2'd1;
  localparam logic [1:0] CMD_ELAPSED = 2'd2;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_MIN    = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;

  localparam logic [15:0] IDLE_INTERVAL = 16'hFFFF;

  // Ramp divider: dividend is 2d (33 bits), divisor is 4n+1 or 4n-1 (34 bits).
  localparam int DVD_W     = 33;
  localparam int DVS_W     = 34;
  localparam int DIV_STEPS = DVD_W;

  typedef struct packed {
    logic [15:0] start_interval;
    logic [15:0] min_interval;
    logic        invert_dir;
  } str_cfg_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic finish;
    logic load_out;
  } str_cmd_t;

  typedef struct packed {
    logic ramp_req;
    logic div_go;
    logic div_done;
  } str_sts_t;

endpackage

/* hdl/str_div.sv */
`timescale 1ns / 1ps
// Radix-2 restoring divider for the ramp update, one quotient bit per cycle.
// Depends on str_pkg for operand widths.
module str_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [str_pkg::DVD_W-1:0] dividend,
  input  logic [str_pkg::DVS_W-1:0] divisor,
  output logic [str_pkg::DVD_W-1:0] quotient,
  output logic                      done
);
  import str_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      // shift the next dividend bit in, subtract when it fits
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign done     = (cnt_r == '0);

endmodule

/* hdl/str_dp.sv */
`timescale 1ns / 1ps
// Datapath: move state, step counting, ramp arithmetic and result register.
// Depends on str_pkg and str_div; driven by str_ctrl through str_cmd_t.
module str_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  str_pkg::str_cfg_t cfg,
  input  str_pkg::str_cmd_t cmd,
  output str_pkg::str_sts_t sts,
  input  logic [1:0]        in_cmd,
  input  logic [31:0]       in_steps_or_target,
  input  logic              in_stop_on_endstop,
  input  logic              in_endstop_hit,
  output logic              out_step_pulse,
  output logic              out_dir_level,
  output logic [15:0]       out_next_interval,
  output logic              out_busy_res,
  output logic              out_move_done,
  output logic [31:0]       out_position
);
  import str_pkg::*;

  logic [31:0] pos_r, ml_r, st_r, n_r, rup_r, d_r;
  logic        dir_r, moving_r, done_r, es_en_r, pulse_r, accel_r;

  logic [31:0] mv_val, mv_len, st_inc, n_inc;
  logic        mv_neg, mv_pin, mv_go, accel_go, decel_go;
  logic [47:0] start_sh, lim_sh;
  logic [31:0] start_fx, lim_fx, whole;
  logic [15:0] next_iv;

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] divisor;
  logic             div_done;

  logic [31:0] d_sub, d_nxt, rup_nxt;
  logic [33:0] d_sum;

  always_comb begin
    mv_val = (in_cmd == CMD_ABS) ? (in_steps_or_target - pos_r) : in_steps_or_target;
    mv_neg = mv_val[31];
    mv_pin = (in_cmd == CMD_REL && cfg.invert_dir) ? !mv_neg : mv_neg;
    mv_go  = (in_cmd == CMD_REL || in_cmd == CMD_ABS) && (mv_val != '0);
    mv_len = mv_neg ? (32'd0 - mv_val) : mv_val;
    st_inc = st_r + 32'd1;
    n_inc  = n_r + 32'd1;

    start_sh = {32'd0, cfg.start_interval} << FRAC_BITS;
    lim_sh   = {32'd0, cfg.min_interval} << FRAC_BITS;
    start_fx = (|start_sh[47:32]) ? 32'hFFFF_FFFF : start_sh[31:0];
    lim_fx   = (|lim_sh[47:32]) ? 32'hFFFF_FFFF : lim_sh[31:0];

    accel_go = (rup_r == '0);
    decel_go = !accel_go && (st_r >= ml_r - rup_r) && (n_r != '0);
    divisor  = accel_go ? {n_inc, 2'b01} : ({n_r, 2'b00} - DVS_W'(1));

    sts.ramp_req = (in_cmd == CMD_ELAPSED) && moving_r && !(es_en_r && in_endstop_hit);
    sts.div_go   = accel_go || decel_go;
    sts.div_done = div_done;
  end

  // apply the quotient: accelerate clamps to the cruise interval, decelerate saturates
  always_comb begin
    d_sub   = (quo > {1'b0, d_r}) ? 32'd0 : (d_r - quo[31:0]);
    d_sum   = {2'b00, d_r} + {1'b0, quo};
    rup_nxt = rup_r;
    if (accel_r) begin
      d_nxt = d_sub;
      if (d_sub <= lim_fx) begin
        d_nxt   = lim_fx;
        rup_nxt = st_r;
      end
      if (st_r >= (ml_r >> 1)) begin
        rup_nxt = st_r;
      end
    end else begin
      d_nxt = (|d_sum[33:32]) ? 32'hFFFF_FFFF : d_sum[31:0];
    end
  end

  str_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({d_r, 1'b0}),
    .divisor  (divisor),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ml_r     <= '0;
      st_r     <= '0;
      n_r      <= '0;
      rup_r    <= '0;
      d_r      <= '0;
      dir_r    <= 1'b0;
      moving_r <= 1'b0;
      done_r   <= 1'b0;
      es_en_r  <= 1'b0;
      pulse_r  <= 1'b0;
      accel_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pulse_r <= 1'b0;
        if (mv_go) begin
          ml_r     <= mv_len;
          dir_r    <= mv_pin;
          d_r      <= start_fx;
          st_r     <= '0;
          n_r      <= '0;
          rup_r    <= '0;
          done_r   <= 1'b0;
          moving_r <= 1'b1;
          es_en_r  <= in_stop_on_endstop;
        end else if (in_cmd == CMD_ELAPSED && moving_r) begin
          if (es_en_r && in_endstop_hit) begin
            // end stop halts the move without a step
            moving_r <= 1'b0;
          end else if (st_r < ml_r) begin
            pulse_r <= 1'b1;
            st_r    <= st_inc;
            pos_r   <= pos_r + (dir_r ? 32'hFFFF_FFFF : 32'd1);
            if (st_inc >= ml_r) begin
              done_r   <= 1'b1;
              moving_r <= 1'b0;
            end
          end
        end
      end
      if (cmd.div_start) begin
        accel_r <= accel_go;
        if (accel_go) begin
          n_r <= n_inc;
        end
      end
      if (cmd.finish) begin
        d_r   <= d_nxt;
        rup_r <= rup_nxt;
        if (!accel_r) begin
          n_r <= n_r - 32'd1;
        end
      end
    end
  end

  always_comb begin
    whole   = d_r >> FRAC_BITS;
    next_iv = (|whole[31:16]) ? IDLE_INTERVAL : whole[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_step_pulse    <= pulse_r;
      out_dir_level     <= dir_r;
      out_next_interval <= moving_r ? next_iv : IDLE_INTERVAL;
      out_busy_res      <= moving_r;
      out_move_done     <= done_r;
      out_position      <= pos_r;
    end
  end

endmodule

/* hdl/str_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences request acceptance, ramp division and result hand-off.
// Depends on str_pkg; commands str_dp through str_cmd_t.
module str_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  str_pkg::str_sts_t sts,
  output str_pkg::str_cmd_t cmd
);
  import str_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RAMP = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.ramp_req ? S_RAMP : S_EMIT;
        end
      end
      S_RAMP: begin
        if (sts.div_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/stepper_trapezoid_ramp.sv */
`timescale 1ns / 1ps
// Stepper pulse-interval generator with a real-time trapezoidal speed ramp.
// Top level: APB register file, str_ctrl and str_dp. Depends on str_pkg.
//
// Usage: each request on the in_ channel (relative move, absolute move or
// interval-elapsed event) yields exactly one result on the out_ channel,
// in order. A request is taken when in_valid is high and in_stall low; a
// result is taken when out_valid is high and out_stall low.
// Sequence: a move, an ignored command or an event that takes no step goes
// from acceptance to the emit state and the output register; a step event
// first passes the ramp state, and one that runs the acceleration or deceleration
// step also waits for the 33-step divider for 2d/(4n+/-1) and its finish state.
// A new request is taken in the cycle after a result enters the output
// register, even while that result still waits for the receiver.
// When the receiver stalls, the result holds in the output register and
// a following result waits inside the block, which stalls new requests.
// Reset (rst_n low, synchronous) clears position and move state and loads
// start_interval 10, min_interval 10000, invert_dir 1.
// Registers: 0x0 start_interval, 0x4 min_interval, 0x8 invert_dir;
// write them only while the block is idle.
module stepper_trapezoid_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_steps_or_target,
  input  logic               in_stop_on_endstop,
  input  logic               in_endstop_hit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_step_pulse,
  output logic               out_dir_level,
  output logic [15:0]        out_next_interval,
  output logic               out_busy_res,
  output logic               out_move_done,
  output logic signed [31:0] out_position,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import str_pkg::*;

  str_cfg_t    cfg_r;
  str_cmd_t    cmd;
  str_sts_t    sts;
  logic        wr_en;
  logic [31:0] pos;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_interval <= 16'd10;
      cfg_r.min_interval   <= 16'd10000;
      cfg_r.invert_dir     <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_START:  cfg_r.start_interval <= pwdata[15:0];
        REG_MIN:    cfg_r.min_interval   <= pwdata[15:0];
        REG_INVERT: cfg_r.invert_dir     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START:  prdata = {16'd0, cfg_r.start_interval};
      REG_MIN:    prdata = {16'd0, cfg_r.min_interval};
      REG_INVERT: prdata = {31'd0, cfg_r.invert_dir};
      default:    prdata = '0;
    endcase
  end

  str_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  str_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_steps_or_target (in_steps_or_target),
    .in_stop_on_endstop (in_stop_on_endstop),
    .in_endstop_hit     (in_endstop_hit),
    .out_step_pulse     (out_step_pulse),
    .out_dir_level      (out_dir_level),
    .out_next_interval  (out_next_interval),
    .out_busy_res       (out_busy_res),
    .out_move_done      (out_move_done),
    .out_position       (pos)
  );

  assign out_position = pos;

endmodule

/* hdl/str_chk.sv */
`timescale 1ns / 1ps
// Port-level checker for stepper_trapezoid_ramp, attached by bind.
// Depends only on the top level's ports.
module str_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_step_pulse,
  input logic [15:0]        out_next_interval,
  input logic               out_busy_res,
  input logic               out_move_done,
  input logic signed [31:0] out_position
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position)
      && $stable(out_step_pulse))
    else $error("stalled result changed");

  // an accepted request keeps the block busy in the next cycle
  a_seq_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  a_idle_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_next_interval == 16'hFFFF)
    else $error("idle result without idle interval");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_busy_res)
    else $error("move reported done while still busy");

endmodule

bind stepper_trapezoid_ramp str_chk u_str_chk (.*);
